// ===== rtl/core/atom_tokenizer_interner_unit_assert.svh =====
// Assertion macros used by the tokenizer controller.
`ifndef ATOM_TOKENIZER_INTERNER_UNIT_ASSERT_SVH
`define ATOM_TOKENIZER_INTERNER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ATI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ATI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/ati_pkg.sv =====
`default_nettype none
package ati_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int NAME_MAX      = 63;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W  = $clog2(NAME_MAX + 1);
    localparam int POS_W  = $clog2(NAME_MAX);
    localparam int STORE_DEPTH = TABLE_ENTRIES * NAME_MAX;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [2:0] K_FOUND   = 3'd0;
    localparam logic [2:0] K_ADDED   = 3'd1;
    localparam logic [2:0] K_PUNCT   = 3'd2;
    localparam logic [2:0] K_TOOLONG = 3'd3;
    localparam logic [2:0] K_FULL    = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] atom_index;
        logic       atom_type;
        logic [7:0] punct_char;
        logic       last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;    // capture input byte
        logic append;      // write byte into pending name
        logic clr_pend;    // drop pending atom
        logic ent_start;   // begin compare at entry 0
        logic ent_next;    // advance to next entry
        logic pos_rst;     // start byte compare of current entry
        logic pos_next;    // advance compare byte
        logic add_start;   // begin copying pending name into table
        logic add_next;    // next copy byte
        logic commit_add;  // write length/type, bump count
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       is_eos;
        logic       is_space;
        logic       is_punct;
        logic       pend_empty;
        logic       pend_full;
        logic       ent_done;   // entry index reached atom_count
        logic       len_match;  // current entry length equals pending length
        logic       pos_done;   // compare position reached pending length
        logic       byte_match; // byte reads valid and registered bytes equal
        logic       table_full;
        logic       add_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/core/ati_if.sv =====
`default_nettype none
interface ati_in_if;
    import ati_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ati_out_if;
    import ati_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ati_ram.sv =====
`default_nettype none
module ati_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/ati_datapath.sv =====
`default_nettype none
module ati_datapath
    import ati_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic [7:0]       o_ch,
    output logic [IDX_W-1:0] o_ent,
    output logic             o_ent_type,
    output logic             o_pend_type,
    output logic [IDX_W-1:0] o_new_idx
);
    logic [7:0]       r_ch;
    logic             r_eos;
    logic [LEN_W-1:0] r_plen;
    logic             r_ptype;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ent;
    logic [CNT_W-1:0] n_ent;
    logic [LEN_W-1:0] r_pos;
    logic             r_rd_vld;
    logic [7:0]       pend_rd;
    logic [7:0]       store_rd;
    logic [LEN_W:0]   meta_rd;   // {type, length} of the entry at r_ent
    logic [POS_W-1:0] pos_idx;
    logic [IDX_W-1:0] ent_idx;
    logic [ADDR_W-1:0] store_raddr;
    logic [ADDR_W-1:0] store_waddr;
    logic             copying;
    logic             r_copy_wr;
    logic [POS_W-1:0] r_copy_pos;

    assign pos_idx = r_pos[POS_W-1:0];
    assign ent_idx = r_ent[IDX_W-1:0];
    assign copying = i_cmd.add_start | i_cmd.add_next;
    // store address: entry * NAME_MAX + byte
    assign store_raddr = ADDR_W'(ent_idx * NAME_MAX) + ADDR_W'(pos_idx);
    assign store_waddr = ADDR_W'(ent_idx * NAME_MAX) + ADDR_W'(r_copy_pos);

    // entry pointer; the length/type table is addressed with the next pointer, so its output matches it
    always_comb begin
        n_ent = r_ent;
        if (i_cmd.ent_start) begin
            n_ent = '0;
        end else if (i_cmd.ent_next) begin
            n_ent = r_ent + 1'b1;
        end else if (i_cmd.add_start) begin
            n_ent = r_count;
        end
    end

    ati_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_pend (
        .i_clk(i_clk), .i_we(i_cmd.append), .i_waddr(r_plen[POS_W-1:0]),
        .i_wdata(r_ch), .i_raddr(pos_idx), .o_rdata(pend_rd)
    );
    ati_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk(i_clk), .i_we(r_copy_wr), .i_waddr(store_waddr),
        .i_wdata(pend_rd), .i_raddr(store_raddr), .o_rdata(store_rd)
    );
    ati_ram #(.WIDTH(LEN_W + 1), .DEPTH(TABLE_ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(i_cmd.commit_add), .i_waddr(ent_idx),
        .i_wdata({r_ptype, r_plen}), .i_raddr(n_ent[IDX_W-1:0]), .o_rdata(meta_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= '0;
            r_ptype  <= 1'b0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_copy_wr <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.pos_rst | i_cmd.pos_next;
            r_copy_wr <= copying;
            if (i_cmd.append) begin
                if (r_plen == '0) begin
                    r_ptype <= (r_ch >= 8'h61) && (r_ch <= 8'h7a);
                end
                r_plen <= r_plen + 1'b1;
            end
            if (i_cmd.clr_pend) begin
                r_plen  <= '0;
                r_ptype <= 1'b0;
            end
            if (i_cmd.commit_add) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_ch  <= i_in.ch;
            r_eos <= i_in.end_of_stream;
        end
        r_ent <= n_ent;
        if (i_cmd.pos_rst | i_cmd.add_start) begin
            r_pos <= '0;
        end else if (i_cmd.pos_next | i_cmd.add_next) begin
            r_pos <= r_pos + 1'b1;
        end
        r_copy_pos <= pos_idx;
    end

    always_comb begin
        o_sts.is_eos     = r_eos;
        o_sts.is_space   = (r_ch == 8'h20) || (r_ch == 8'h0a) || (r_ch == 8'h09) ||
                           (r_ch == 8'h0d) || (r_ch == 8'h0c);
        o_sts.is_punct   = (r_ch == 8'h28) || (r_ch == 8'h29) || (r_ch == 8'h5b) ||
                           (r_ch == 8'h5d) || (r_ch == 8'h2c);
        o_sts.pend_empty = (r_plen == '0);
        o_sts.pend_full  = (r_plen >= LEN_W'(NAME_MAX));
        o_sts.ent_done   = (r_ent >= r_count);
        o_sts.len_match  = (meta_rd[LEN_W-1:0] == r_plen);
        o_sts.pos_done   = (r_pos >= r_plen);
        o_sts.byte_match = r_rd_vld && (store_rd == pend_rd);
        o_sts.table_full = (r_count >= CNT_W'(TABLE_ENTRIES));
        o_sts.add_done   = (r_pos >= r_plen);
    end

    assign o_ch        = r_ch;
    assign o_ent       = ent_idx;
    assign o_ent_type  = meta_rd[LEN_W];
    assign o_pend_type = r_ptype;
    assign o_new_idx   = r_count[IDX_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/ati_ctrl.sv =====
`default_nettype none
module ati_ctrl
    import ati_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts,
    input  wire logic [7:0]       i_ch,
    input  wire logic [IDX_W-1:0] i_ent,
    input  wire logic             i_ent_type,
    input  wire logic             i_pend_type,
    input  wire logic [IDX_W-1:0] i_new_idx
);
    `include "atom_tokenizer_interner_unit_assert.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_ENT   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_ADDW  = 4'd6;
    localparam logic [3:0] S_OUT1  = 4'd7;
    localparam logic [3:0] S_PUNCT = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_vld, n_vld;
    t_out       r_out, n_out;
    t_out       r_res, n_res;     // atom result staged until the output is free
    logic       r_more, n_more;   // punctuation follows atom result

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_more  <= n_more;
        end
        r_out <= n_out;
        r_res <= n_res;
    end

    function automatic t_out mk(input logic [2:0] k, input logic [5:0] idx,
                                input logic ty, input logic [7:0] p, input logic l);
        t_out o;
        o.kind = k; o.atom_index = idx; o.atom_type = ty; o.punct_char = p; o.last = l;
        return o;
    endfunction

    logic out_free;
    assign out_free = !r_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_vld   = r_vld && !i_out_ready;
        n_out   = r_out;
        n_res   = r_res;
        n_more  = r_more;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_eos || i_sts.is_space || i_sts.is_punct) begin
                    n_more = !i_sts.is_eos && i_sts.is_punct;
                    if (!i_sts.pend_empty) begin
                        o_cmd.ent_start = 1'b1;
                        n_state = S_ENT;
                    end else if (n_more) begin
                        n_state = S_PUNCT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_sts.pend_full) begin
                    if (out_free) begin
                        o_cmd.clr_pend = 1'b1;
                        n_vld = 1'b1;
                        n_out = mk(K_TOOLONG, '0, 1'b0, '0, 1'b1);
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.append = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ENT: begin
                if (i_sts.ent_done) begin
                    if (i_sts.table_full) begin
                        n_res = mk(K_FULL, '0, 1'b0, '0, !r_more);
                        n_state = S_OUT1;
                    end else begin
                        o_cmd.add_start = 1'b1;
                        n_state = S_ADD;
                    end
                end else if (i_sts.len_match) begin
                    o_cmd.pos_rst = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.ent_next = 1'b1;
                end
            end
            S_RD: begin
                // first read in flight
                if (i_sts.pos_done) begin
                    n_res = mk(K_FOUND, 6'(i_ent), i_ent_type, '0, !r_more);
                    n_state = S_OUT1;
                end else begin
                    o_cmd.pos_next = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.byte_match) begin
                    o_cmd.ent_next = 1'b1;
                    n_state = S_ENT;
                end else if (i_sts.pos_done) begin
                    n_res = mk(K_FOUND, 6'(i_ent), i_ent_type, '0, !r_more);
                    n_state = S_OUT1;
                end else begin
                    o_cmd.pos_next = 1'b1;
                end
            end
            S_ADD: begin
                if (i_sts.add_done) begin
                    n_state = S_ADDW;
                end else begin
                    o_cmd.add_next = 1'b1;
                end
            end
            S_ADDW: begin
                // last store write has landed
                o_cmd.commit_add = 1'b1;
                n_res = mk(K_ADDED, 6'(i_new_idx), i_pend_type, '0, !r_more);
                n_state = S_OUT1;
            end
            S_OUT1: begin
                if (out_free) begin
                    n_vld = 1'b1;
                    n_out = r_res;
                    o_cmd.clr_pend = 1'b1;
                    n_state = r_more ? S_PUNCT : S_IDLE;
                end
            end
            S_PUNCT: begin
                if (out_free) begin
                    n_vld = 1'b1;
                    n_out = mk(K_PUNCT, '0, 1'b0, i_ch, 1'b1);
                    n_more = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_vld;
    assign o_out       = r_out;

    `ATI_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE,
        "input taken outside idle")
    `ATI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_vld && !i_out_ready,
        r_vld && $stable(r_out), "stalled result changed")
    `ATI_ASSERT_IMP(a_punct_last, i_clk, i_rst_n, r_vld && r_out.kind == K_PUNCT,
        r_out.last, "punctuation result not last")
endmodule
`default_nettype wire

// ===== rtl/core/atom_tokenizer_interner_unit.sv =====
// Sequence: a plain character is accepted, then decoded. A closing byte scans the
//   table: entries of another length are skipped, entries of equal length are compared
//   byte by byte; a new name is copied in; the result is loaded once the output is free.
// Throughput: one transaction at a time; input waits while a closing byte scans the
//   table, one entry and one byte per cycle. A stalled result holds.
// Reset: synchronous active low; clears count, pending length and control. The
//   name store needs no clearing pass; only entries below the count are read.
`default_nettype none
module atom_tokenizer_interner_unit
    import ati_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    ati_in_if.sink   i_in,
    ati_out_if.source o_out
);
    t_cmd cmd;
    t_sts sts;
    logic [7:0]       ch;
    logic [IDX_W-1:0] ent;
    logic             ent_type;
    logic             pend_type;
    logic [IDX_W-1:0] new_idx;

    // controller: sequencing, handshake, result register
    ati_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready), .o_out(o_out.data),
        .o_cmd(cmd), .i_sts(sts), .i_ch(ch), .i_ent(ent), .i_ent_type(ent_type),
        .i_pend_type(pend_type), .i_new_idx(new_idx)
    );

    // datapath: pending name, name store, length/type table
    ati_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in.data), .i_cmd(cmd),
        .o_sts(sts), .o_ch(ch), .o_ent(ent), .o_ent_type(ent_type),
        .o_pend_type(pend_type), .o_new_idx(new_idx)
    );
endmodule
`default_nettype wire

// ===== tb/sv/ati_scoreboard.sv =====
`default_nettype none
module ati_scoreboard
    import ati_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ati_in_if         i_in,
    ati_out_if        i_out,
    output int        o_fail_cnt,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]       name_tab [TABLE_ENTRIES][NAME_MAX];
    logic [LEN_W-1:0] name_len [TABLE_ENTRIES];
    logic             name_var [TABLE_ENTRIES];
    int               intern_cnt;
    logic [7:0]       pend_name [NAME_MAX];
    int               pend_len;
    logic             pend_var;
    t_out             tok_q [$];

    assign o_outstanding = tok_q.size();

    function automatic t_out mk_tok(logic [2:0] k, logic [5:0] idx, logic ty,
                                    logic [7:0] pc);
        t_out t;
        t.kind       = k;
        t.atom_index = idx;
        t.atom_type  = ty;
        t.punct_char = pc;
        t.last       = 1'b0;
        return t;
    endfunction

    task automatic close_atom();
        bit hit;
        int e;
        hit = 0;
        if (pend_len != 0) begin
            for (e = 0; e < intern_cnt && !hit; e++) begin
                if (name_len[e] == pend_len) begin
                    hit = 1;
                    for (int b = 0; b < pend_len; b++)
                        if (name_tab[e][b] != pend_name[b]) hit = 0;
                    if (hit) tok_q.push_back(mk_tok(K_FOUND, e[5:0], name_var[e], 8'd0));
                end
            end
            if (!hit) begin
                if (intern_cnt >= TABLE_ENTRIES) begin
                    tok_q.push_back(mk_tok(K_FULL, 6'd0, 1'b0, 8'd0));
                end else begin
                    for (int b = 0; b < pend_len; b++) name_tab[intern_cnt][b] = pend_name[b];
                    name_len[intern_cnt] = LEN_W'(pend_len);
                    name_var[intern_cnt] = pend_var;
                    tok_q.push_back(mk_tok(K_ADDED, intern_cnt[5:0], pend_var, 8'd0));
                    intern_cnt++;
                end
            end
            pend_len = 0;
            pend_var = 1'b0;
        end
    endtask

    task automatic tokenize(t_in it);
        int before_n;
        logic [7:0] c;
        before_n = tok_q.size();
        c = it.ch;
        if (it.end_of_stream || c == " " || c == 8'h0a || c == 8'h09 ||
            c == 8'h0d || c == 8'h0c) begin
            close_atom();
        end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == ",") begin
            close_atom();
            tok_q.push_back(mk_tok(K_PUNCT, 6'd0, 1'b0, c));
        end else if (pend_len >= NAME_MAX) begin
            tok_q.push_back(mk_tok(K_TOOLONG, 6'd0, 1'b0, 8'd0));
            pend_len = 0;
            pend_var = 1'b0;
        end else begin
            if (pend_len == 0) pend_var = (c >= "a" && c <= "z");
            pend_name[pend_len] = c;
            pend_len++;
        end
        if (tok_q.size() > before_n) tok_q[tok_q.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_out exp_t;
        if (!i_rst_n) begin
            intern_cnt = 0;
            pend_len   = 0;
            pend_var   = 1'b0;
            o_fail_cnt = 0;
            tok_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (tok_q.size() == 0) begin
                    $display("%0t: unexpected transaction %p", $time, i_out.data);
                    o_fail_cnt++;
                end else begin
                    exp_t = tok_q.pop_front();
                    if (exp_t.kind != i_out.data.kind ||
                        exp_t.atom_index != i_out.data.atom_index ||
                        exp_t.atom_type != i_out.data.atom_type ||
                        exp_t.punct_char != i_out.data.punct_char ||
                        exp_t.last != i_out.data.last) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_t, i_out.data);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) tokenize(i_in.data);
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
    import ati_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int POOL_N      = 90;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   outstanding;
    int   cycles = 0;
    int   sent = 0;

    ati_in_if  in_ch();
    ati_out_if out_ch();

    atom_tokenizer_interner_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    ati_scoreboard checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_cnt   (fail_cnt),
        .o_outstanding(outstanding)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver backpressure: randomly chosen modes, some long always-ready stretches
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 120);
        end
        stall_left--;
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= cycles[2];
        endcase
    end

    // sender burst state
    int burst_left = 0;

    // One transaction; valid stays high inside a burst, sometimes a gap between bursts.
    task automatic send_tx(logic [7:0] c, logic eos);
        t_in it;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        it.ch = c;
        it.end_of_stream = eos;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic send_str(string s);
        for (int k = 0; k < s.len(); k++) send_tx(s[k], 1'b0);
    endtask

    function automatic bit is_sep(logic [7:0] c);
        return c == " " || c == 8'h0a || c == 8'h09 || c == 8'h0d || c == 8'h0c ||
               c == "(" || c == ")" || c == "[" || c == "]" || c == ",";
    endfunction

    logic [7:0] pool_ch [POOL_N][8];
    int         pool_len [POOL_N];

    task automatic send_separator();
        logic [7:0] seps [10];
        seps = '{" ", 8'h0a, 8'h09, 8'h0d, 8'h0c, "(", ")", "[", "]", ","};
        if ($urandom_range(0, 9) == 0) send_tx(8'($urandom), 1'b1);
        else send_tx(seps[$urandom_range(0, 9)], 1'b0);
    endtask

    initial begin
        logic [7:0] c;
        int p;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        // name pool; more names than table slots so the table overflows
        for (int n = 0; n < POOL_N; n++) begin
            pool_len[n] = (n % 7 == 0) ? $urandom_range(6, 8) : $urandom_range(1, 4);
            for (int b = 0; b < 8; b++) begin
                do begin
                    if ($urandom_range(0, 1)) c = 8'($urandom_range("a", "z"));
                    else c = 8'($urandom);
                end while (is_sep(c));
                pool_ch[n][b] = c;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: eos and whitespace at idle, variable/constant, found, punct
        send_tx(8'hff, 1'b1);
        send_tx(" ", 1'b0);
        send_str("x\tABC\n");
        send_str("x(");
        send_str(")[],");
        send_tx(8'h00, 1'b0);            // NUL is an atom character
        send_tx(8'h0c, 1'b0);
        send_str("z");
        send_tx(8'h00, 1'b1);            // end of stream closes pending atom
        send_str("ABC\r");
        // overlong: NAME_MAX chars then one more gives too_long
        for (int k = 0; k < NAME_MAX + 1; k++) send_tx("q", 1'b0);
        send_str("w ");
        send_tx(8'h7f, 1'b0);
        send_tx(8'h80, 1'b1);

        // random: mostly well-formed tokens from the pool, some noise
        while (sent < 1300) begin
            if (sent > 600 && sent < 640) begin
                // drain: no transaction offered while waiting
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                burst_left = 0;
                wait (outstanding == 0);
            end
            case ($urandom_range(0, 19))
                0, 1, 2: send_tx(8'($urandom), 1'($urandom));
                3: send_separator();
                default: begin
                    p = $urandom_range(0, POOL_N - 1);
                    for (int b = 0; b < pool_len[p]; b++) send_tx(pool_ch[p][b], 1'b0);
                    send_separator();
                end
            endcase
        end
        // one longest name, then close
        for (int k = 0; k < NAME_MAX; k++) send_tx("M", 1'b0);
        send_tx(" ", 1'b0);
        send_str("q)");

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ati_pkg.sv
rtl/core/ati_if.sv
rtl/core/ati_ram.sv
rtl/core/ati_datapath.sv
rtl/core/ati_ctrl.sv
rtl/core/atom_tokenizer_interner_unit.sv
tb/sv/ati_scoreboard.sv
tb/sv/tb.sv
